>>> rtl/multi_slot_presence_debouncer_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slot presence debouncer
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_PRESENCE_DEBOUNCER_UNIT_DEFINES_SVH
`define MULTI_SLOT_PRESENCE_DEBOUNCER_UNIT_DEFINES_SVH

// Plain property check under reset.
`define MSDB_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// Implication check: cond must lead to result.
`define MSDB_ASSERT_IMP(name, clk, rst_n, cond, result) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (result)) \
        else $error("%m: implication failed");

`endif

>>> rtl/msdb_pkg.sv
// ----------------------------------------------------------------------------
// msdb_pkg
// Types and constants for the slot presence debouncer.
// ----------------------------------------------------------------------------
package msdb_pkg;

    localparam int SLOTS    = 8;
    localparam int SLOT_W   = 3;
    localparam int DET_W    = 2;
    localparam int CNT_W    = 4;
    localparam int RANGE_W  = 7;

    localparam logic [CNT_W-1:0] CNT_MAX    = 4'd15;
    localparam logic [CNT_W-1:0] THR_RESET  = 4'd3;

    localparam logic             CMD_POLL   = 1'b0;
    localparam logic             CMD_START  = 1'b1;

    localparam logic [DET_W-1:0] DET_ABSENT  = 2'd0;
    localparam logic [DET_W-1:0] DET_PRESENT = 2'd1;

    typedef struct packed {
        logic              cmd;
        logic [SLOT_W-1:0] slot;
        logic [DET_W-1:0]  det;
    } item_t;

    typedef struct packed {
        logic              event_valid;
        logic [SLOT_W-1:0] event_slot;
        logic              stable_now;
    } result_t;

endpackage

>>> rtl/msdb_in_stage.sv
// ----------------------------------------------------------------------------
// msdb_in_stage
// Input register: holds one accepted sample until the core consumes it.
// ----------------------------------------------------------------------------
module msdb_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  msdb_pkg::item_t in_item,
    output logic           item_valid,
    output msdb_pkg::item_t item,
    input  logic           item_take
);
    import msdb_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Free when empty or when the held beat moves on this cycle.
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/msdb_slot_core.sv
// ----------------------------------------------------------------------------
// msdb_slot_core
// Per-slot debounce state and its read-modify-write update.
// ----------------------------------------------------------------------------
module msdb_slot_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  msdb_pkg::item_t               item,
    input  logic [msdb_pkg::CNT_W-1:0]    threshold,
    output msdb_pkg::result_t             result
);
    import msdb_pkg::*;

    logic             stable_reg [SLOTS];
    logic             pend_reg   [SLOTS];
    logic [CNT_W-1:0] cnt_reg    [SLOTS];

    logic             in_range;
    logic             known;
    logic             det_bit;
    logic             cur_stable;
    logic             cur_pend;
    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] thr_eff;
    logic [CNT_W-1:0] cnt_step;
    logic             stable_next;
    logic             pend_next;
    logic [CNT_W-1:0] cnt_next;
    logic             ev;

    assign in_range   = ({{(RANGE_W-SLOT_W){1'b0}}, item.slot} < RANGE_W'(SLOTS));
    assign known      = (item.det == DET_ABSENT) || (item.det == DET_PRESENT);
    assign det_bit    = item.det[0];
    assign cur_stable = stable_reg[item.slot];
    assign cur_pend   = pend_reg[item.slot];
    assign cur_cnt    = cnt_reg[item.slot];
    // a zero threshold acts as one
    assign thr_eff    = (threshold == '0) ? CNT_W'(1) : threshold;

    always_comb
    begin
        stable_next = cur_stable;
        pend_next   = cur_pend;
        cnt_next    = cur_cnt;
        cnt_step    = cur_cnt;
        ev          = 1'b0;
        case (item.cmd)
            CMD_START:
            begin
                stable_next = (item.det == DET_PRESENT);
                ev          = stable_next;
            end
            CMD_POLL:
            begin
                if (!known || det_bit == cur_stable)
                begin
                    cnt_next = '0;
                end
                else
                begin
                    if (det_bit == cur_pend)
                    begin
                        cnt_step = (cur_cnt == CNT_MAX) ? CNT_MAX : cur_cnt + CNT_W'(1);
                    end
                    else
                    begin
                        pend_next = det_bit;
                        cnt_step  = CNT_W'(1);
                    end
                    if (cnt_step >= thr_eff)
                    begin
                        stable_next = det_bit;
                        cnt_next    = '0;
                        ev          = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_step;
                    end
                end
            end
            default:
            begin
                cnt_next = cur_cnt;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                stable_reg[i] <= 1'b0;
                pend_reg[i]   <= 1'b0;
                cnt_reg[i]    <= '0;
            end
        end
        else if (fire && in_range)
        begin
            stable_reg[item.slot] <= stable_next;
            pend_reg[item.slot]   <= pend_next;
            cnt_reg[item.slot]    <= cnt_next;
        end
    end

    assign result.event_valid = in_range && ev;
    assign result.event_slot  = item.slot;
    assign result.stable_now  = in_range && stable_next;

endmodule

>>> rtl/msdb_out_stage.sv
// ----------------------------------------------------------------------------
// msdb_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module msdb_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  msdb_pkg::result_t result,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output msdb_pkg::result_t out_result
);
    import msdb_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

>>> rtl/multi_slot_presence_debouncer_unit.sv
// ----------------------------------------------------------------------------
// multi_slot_presence_debouncer_unit
// Debounces presence detect samples for eight module slots.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat is a sample, cmd, slot_index and
// detect_value. A poll sample is debounced against the slot's stable state; a
// start sample loads the stable state directly.
// Output channel (out_valid/out_ready): one result beat per input beat, in
// order: event_valid, event_slot and stable_now.
// Config channel (cfg_valid/cfg_ready): writes debounce_threshold; always
// ready. Write it only while no sample is in flight.
// Pipeline: a sample accepted into the input register moves on to the result
// register when that register can load. Throughput: one sample per cycle
// while out_ready is high, set by the read-modify-write of the per-slot state
// between the input register and the result register.
// Reset: all slots absent, counters clear, threshold 3, both registers empty.
// Receiver stall: the result register holds its beat; the input register
// holds one more sample, after which in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module multi_slot_presence_debouncer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [msdb_pkg::SLOT_W-1:0]   slot_index,
    input  logic [msdb_pkg::DET_W-1:0]    detect_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          event_valid,
    output logic [msdb_pkg::SLOT_W-1:0]   event_slot,
    output logic                          stable_now,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [msdb_pkg::CNT_W-1:0]    debounce_threshold
);
    import msdb_pkg::*;

    logic [CNT_W-1:0] thr_reg;
    item_t            in_item;
    item_t            item;
    logic             item_valid;
    logic             can_load;
    logic             fire;
    result_t          result;
    result_t          out_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= debounce_threshold;
        end
    end

    assign in_item.cmd  = cmd;
    assign in_item.slot = slot_index;
    assign in_item.det  = detect_value;

    // slot state is updated in the same cycle the beat moves to the result
    assign fire = item_valid && can_load;

    msdb_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (fire)
    );

    msdb_slot_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .threshold (thr_reg),
        .result    (result)
    );

    msdb_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .result     (result),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    assign event_valid = out_result.event_valid;
    assign event_slot  = out_result.event_slot;
    assign stable_now  = out_result.stable_now;

endmodule

>>> rtl/msdb_checker.sv
// ----------------------------------------------------------------------------
// msdb_checker
// Port-level checks for the slot presence debouncer, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_slot_presence_debouncer_unit_defines.svh"

module msdb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        event_valid,
    input logic [msdb_pkg::SLOT_W-1:0] event_slot,
    input logic                        stable_now,
    input logic                        cfg_ready
);
    import msdb_pkg::*;

    // stalled result beat must hold
    `MSDB_ASSERT_IMP(a_out_hold, clk, rst_n, out_valid && !out_ready, ##1 (out_valid && $stable(event_valid) && $stable(event_slot) && $stable(stable_now)))
    // every accepted sample is followed by a valid result beat at the output
    `MSDB_ASSERT_IMP(a_in_to_out, clk, rst_n, in_valid && in_ready, ##2 out_valid)
    // a fresh result beat must come from an accepted sample, not appear on its own
    `MSDB_ASSERT_IMP(a_no_invent, clk, rst_n, out_valid && !$past(out_valid), $past(in_valid && in_ready, 2))
    `MSDB_ASSERT(a_cfg_ready, clk, rst_n, cfg_ready)

endmodule

bind multi_slot_presence_debouncer_unit msdb_checker u_msdb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_valid (event_valid),
    .event_slot  (event_slot),
    .stable_now  (stable_now),
    .cfg_ready   (cfg_ready)
);
